// ===== rtl/core/gld_pkg.sv =====
// ----------------------------------------------------------------------------
// gld_pkg
// Shared widths, register codes and the records passed between the front end,
// the back end and the queues of the grid local minimum detector.
// ----------------------------------------------------------------------------
package gld_pkg;

    localparam int COL_W      = 6;
    localparam int ROW_W      = 11;
    localparam int PROW_W     = 10;
    localparam int HGT_W      = 4;
    localparam int RISK_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [COL_W-1:0]  FW_RESET = 6'd63;
    localparam logic [ROW_W-1:0]  FH_RESET = 11'd1024;
    localparam logic [RISK_W-1:0] RISK_MAX = 20'hFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // classified pixel, front end to back end
    typedef struct packed {
        logic [HGT_W-1:0] height;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             first;   // pixel of row 0
        logic             last;    // last pixel of the frame
    } pix_item_t;

    typedef struct packed {
        logic [COL_W-1:0] wlast;   // effective width minus one
        logic             restart; // register write, frame starts over
    } frame_ctrl_t;

    typedef struct packed {
        logic [PROW_W-1:0] pixel_row;
        logic [COL_W-1:0]  pixel_column;
        logic [HGT_W-1:0]  pixel_height;
        logic              is_low_point;
        logic [RISK_W-1:0] risk_total;
        logic              frame_done;
    } result_t;

endpackage

// ===== rtl/core/grid_local_minimum_detector.sv =====
// ----------------------------------------------------------------------------
// grid_local_minimum_detector
// Finds 4-neighbour local minima of a height map streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels enter through push/full: a request is taken at a clock edge with push
// high and full low. Decisions leave through empty/pop in raster order: the
// head result sits on the result ports while empty is low and is removed at an
// edge with pop high. A pixel's decision comes out when the pixel below it
// arrives; the last pixel of the frame also releases the whole last row, the
// final one flagged frame_done. risk_total carries the running sum of one plus
// height over low points and clears after frame_done.
// Throughput: one pixel per cycle while the result queue has room, set by the
// two-stage decision pipeline over the row stores; the end-of-frame sweep of
// the last row occupies the back end while the front end keeps taking pixels
// until its 4-entry queue fills. A stalled receiver fills the 2-entry result
// queue, then the pipeline and the pixel queue hold, and full rises. Frame
// size writes on the cfg channel (always ready) restart the frame; the user
// must make them only while the block is idle; the block does not enforce it.
// Reset empties both queues and restores 63 x 1024; row stores are not cleared.
// ----------------------------------------------------------------------------
module grid_local_minimum_detector #(
    parameter int MAX_WIDTH  = 63,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gld_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [gld_pkg::HGT_W-1:0]        height,
    output logic                             empty,
    input  logic                             pop,
    output logic [gld_pkg::PROW_W-1:0]       pixel_row,
    output logic [gld_pkg::COL_W-1:0]        pixel_column,
    output logic [gld_pkg::HGT_W-1:0]        pixel_height,
    output logic                             is_low_point,
    output logic [gld_pkg::RISK_W-1:0]       risk_total,
    output logic                             frame_done
);

    gld_pkg::frame_ctrl_t ctrl;
    gld_pkg::pix_item_t   front_item, back_item;
    gld_pkg::result_t     back_res, head_res;
    logic                 item_push, item_pop, q_empty;
    logic                 res_push, res_full;

    gld_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_valid  (push),
        .pix_height (height),
        .q_full     (full),
        .item_push  (item_push),
        .item       (front_item),
        .ctrl       (ctrl)
    );

    gld_fifo #(
        .WIDTH ($bits(gld_pkg::pix_item_t)),
        .DEPTH (4)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata (front_item),
        .full  (full),
        .pop   (item_pop),
        .rdata (back_item),
        .empty (q_empty)
    );

    gld_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .item_valid (!q_empty),
        .item       (back_item),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res)
    );

    gld_fifo #(
        .WIDTH ($bits(gld_pkg::result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (head_res),
        .empty (empty)
    );

    assign pixel_row    = head_res.pixel_row;
    assign pixel_column = head_res.pixel_column;
    assign pixel_height = head_res.pixel_height;
    assign is_low_point = head_res.is_low_point;
    assign risk_total   = head_res.risk_total;
    assign frame_done   = head_res.frame_done;

endmodule

// ===== rtl/core/gld_ram.sv =====
// ----------------------------------------------------------------------------
// gld_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module gld_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 63
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/gld_fifo.sv =====
// ----------------------------------------------------------------------------
// gld_fifo
// Small register FIFO with full and empty flags; push and pop may coincide.
// ----------------------------------------------------------------------------
module gld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/gld_front.sv =====
// ----------------------------------------------------------------------------
// gld_front
// Frame size registers and raster position tracking. Tags each accepted pixel
// with its column and row and marks the first row and the end of the frame.
// ----------------------------------------------------------------------------
module gld_front #(
    parameter int MAX_WIDTH  = 63,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gld_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             pix_valid,
    input  logic [gld_pkg::HGT_W-1:0]        pix_height,
    input  logic                             q_full,
    output logic                             item_push,
    output gld_pkg::pix_item_t               item,
    output gld_pkg::frame_ctrl_t             ctrl
);

    // frame_height is 11 bits wide, so no clamp above 2047 ever applies
    localparam int HCLAMP = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;

    logic [gld_pkg::COL_W-1:0] fw_reg, fw_next;
    logic [gld_pkg::ROW_W-1:0] fh_reg, fh_next;
    logic [gld_pkg::COL_W-1:0] col_reg, col_next;
    logic [gld_pkg::ROW_W-1:0] row_reg, row_next;
    logic [gld_pkg::COL_W-1:0] wlast;
    logic [gld_pkg::ROW_W-1:0] hlast;
    logic                      last;
    logic                      cfg_hit;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (fw_reg == '0)
        begin
            wlast = '0;
        end
        else if (fw_reg > gld_pkg::COL_W'(MAX_WIDTH))
        begin
            wlast = gld_pkg::COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = fw_reg - 1'b1;
        end

        if (fh_reg == '0)
        begin
            hlast = '0;
        end
        else if (fh_reg > gld_pkg::ROW_W'(HCLAMP))
        begin
            hlast = gld_pkg::ROW_W'(HCLAMP - 1);
        end
        else
        begin
            hlast = fh_reg - 1'b1;
        end
    end

    assign last      = (col_reg == wlast) && (row_reg >= hlast);
    assign item_push = pix_valid && !q_full;

    always_comb
    begin
        item.height = pix_height;
        item.col    = col_reg;
        item.row    = row_reg;
        item.first  = (row_reg == '0);
        item.last   = last;
    end

    always_comb
    begin
        fw_next  = fw_reg;
        fh_next  = fh_reg;
        col_next = col_reg;
        row_next = row_reg;
        cfg_hit  = 1'b0;

        if (cfg_valid)
        begin
            unique case (gld_pkg::cfg_reg_t'(cfg_index))
                gld_pkg::REG_FRAME_WIDTH:
                begin
                    fw_next = cfg_data[gld_pkg::COL_W-1:0];
                    cfg_hit = 1'b1;
                end
                gld_pkg::REG_FRAME_HEIGHT:
                begin
                    fh_next = cfg_data;
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (item_push)
        begin
            priority if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == wlast)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        ctrl.wlast   = wlast;
        ctrl.restart = cfg_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= gld_pkg::FW_RESET;
            fh_reg  <= gld_pkg::FH_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            fw_reg  <= fw_next;
            fh_reg  <= fh_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/gld_back.sv =====
// ----------------------------------------------------------------------------
// gld_back
// Two-stage decision pipeline over the two row stores. Stage one addresses the
// stores, stage two compares against the neighbours, updates the stores and the
// risk total, and hands the decision to the result queue. At the end of a frame
// a sweep walks the last row and decides it without a lower neighbour.
// ----------------------------------------------------------------------------
module gld_back #(
    parameter int MAX_WIDTH = 63
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gld_pkg::frame_ctrl_t ctrl,
    input  logic                 item_valid,
    input  gld_pkg::pix_item_t   item,
    output logic                 item_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output gld_pkg::result_t     res
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef struct packed {
        logic                        emit;
        logic                        is_item;
        logic                        first;
        logic                        has_up;
        logic                        has_down;
        logic                        done;
        logic [gld_pkg::COL_W-1:0]   col;
        logic [gld_pkg::COL_W-1:0]   col_b;
        logic [gld_pkg::ROW_W-1:0]   row;
        logic [gld_pkg::HGT_W-1:0]   h;
    } op_t;

    // store write that happened at the edge the stage-two read was taken
    typedef struct packed {
        logic                        mid_we;
        logic                        up_we;
        logic [gld_pkg::COL_W-1:0]   addr;
        logic [gld_pkg::HGT_W-1:0]   mid_data;
        logic [gld_pkg::HGT_W-1:0]   up_data;
    } fwd_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FLUSH = 2'b10
    } back_state_t;

    back_state_t               state_reg, state_next;
    logic [gld_pkg::COL_W-1:0] flush_x_reg, flush_x_next;
    logic [gld_pkg::ROW_W-1:0] flush_row_reg, flush_row_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s2_valid_reg;
    op_t                       s1_op_reg, s1_load;
    op_t                       s2_op_reg;
    op_t                       item_op, flush_op;
    fwd_t                      fwd_reg, fwd_next;
    logic [gld_pkg::HGT_W-1:0] left_reg;
    logic [gld_pkg::RISK_W-1:0] risk_reg, risk_next, risk_new, risk_sat;
    logic [gld_pkg::RISK_W:0]  risk_sum;

    logic                      adv, fire;
    logic [gld_pkg::HGT_W-1:0] mid_a_rd, mid_b_rd, up_rd;
    logic [gld_pkg::HGT_W-1:0] mid, right, up;
    logic                      has_left, has_right, low;
    logic                      mid_we, up_we;

    assign adv  = !s2_valid_reg || !res_full;
    assign fire = s2_valid_reg && adv;

    // ---------------- stage one load ----------------
    always_comb
    begin
        item_op.emit     = !item.first;
        item_op.is_item  = 1'b1;
        item_op.first    = item.first;
        item_op.has_up   = (item.row >= gld_pkg::ROW_W'(2));
        item_op.has_down = 1'b1;
        item_op.done     = 1'b0;
        item_op.col      = item.col;
        item_op.col_b    = (item.col != ctrl.wlast) ? item.col + 1'b1 : item.col;
        item_op.row      = item.row - 1'b1;
        item_op.h        = item.height;

        flush_op.emit     = 1'b1;
        flush_op.is_item  = 1'b0;
        flush_op.first    = 1'b0;
        flush_op.has_up   = (flush_row_reg != '0);
        flush_op.has_down = 1'b0;
        flush_op.done     = (flush_x_reg == ctrl.wlast);
        flush_op.col      = flush_x_reg;
        flush_op.col_b    = (flush_x_reg != ctrl.wlast) ? flush_x_reg + 1'b1 : flush_x_reg;
        flush_op.row      = flush_row_reg;
        flush_op.h        = '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        flush_x_next   = flush_x_reg;
        flush_row_next = flush_row_reg;
        s1_valid_next  = s1_valid_reg;
        s1_load        = item_op;
        item_pop       = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                s1_load = item_op;
                if (adv)
                begin
                    s1_valid_next = item_valid;
                    item_pop      = item_valid;
                    if (item_valid && item.last)
                    begin
                        state_next     = ST_FLUSH;
                        flush_x_next   = '0;
                        flush_row_next = item.row;
                    end
                end
            end
            ST_FLUSH:
            begin
                s1_load = flush_op;
                if (adv)
                begin
                    s1_valid_next = 1'b1;
                    if (flush_x_reg == ctrl.wlast)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        flush_x_next = flush_x_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // ---------------- row stores ----------------
    // middle row kept twice so the pixel and its right neighbour read together
    gld_ram #(
        .WIDTH (gld_pkg::HGT_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_a_ram (
        .clk   (clk),
        .we    (mid_we),
        .waddr (s2_op_reg.col[AW-1:0]),
        .wdata (s2_op_reg.h),
        .re    (adv),
        .raddr (s1_op_reg.col[AW-1:0]),
        .rdata (mid_a_rd)
    );

    gld_ram #(
        .WIDTH (gld_pkg::HGT_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_b_ram (
        .clk   (clk),
        .we    (mid_we),
        .waddr (s2_op_reg.col[AW-1:0]),
        .wdata (s2_op_reg.h),
        .re    (adv),
        .raddr (s1_op_reg.col_b[AW-1:0]),
        .rdata (mid_b_rd)
    );

    gld_ram #(
        .WIDTH (gld_pkg::HGT_W),
        .DEPTH (MAX_WIDTH)
    ) u_up_ram (
        .clk   (clk),
        .we    (up_we),
        .waddr (s2_op_reg.col[AW-1:0]),
        .wdata (mid),
        .re    (adv),
        .raddr (s1_op_reg.col[AW-1:0]),
        .rdata (up_rd)
    );

    // ---------------- stage two decide ----------------
    always_comb
    begin
        mid   = (fwd_reg.mid_we && fwd_reg.addr == s2_op_reg.col)   ? fwd_reg.mid_data : mid_a_rd;
        right = (fwd_reg.mid_we && fwd_reg.addr == s2_op_reg.col_b) ? fwd_reg.mid_data : mid_b_rd;
        up    = (fwd_reg.up_we && fwd_reg.addr == s2_op_reg.col)    ? fwd_reg.up_data  : up_rd;

        has_left  = (s2_op_reg.col != '0);
        has_right = (s2_op_reg.col != ctrl.wlast);

        low = !(s2_op_reg.has_up && up <= mid)
           && !(has_left && left_reg <= mid)
           && !(has_right && right <= mid)
           && !(s2_op_reg.has_down && s2_op_reg.h <= mid);

        risk_sum = {1'b0, risk_reg} + (gld_pkg::RISK_W + 1)'(mid) + 1'b1;
        risk_sat = risk_sum[gld_pkg::RISK_W] ? gld_pkg::RISK_MAX : risk_sum[gld_pkg::RISK_W-1:0];
        risk_new = low ? risk_sat : risk_reg;

        mid_we = fire && s2_op_reg.is_item;
        up_we  = fire && s2_op_reg.is_item && !s2_op_reg.first;

        res_push         = fire && s2_op_reg.emit;
        res.pixel_row    = s2_op_reg.row[gld_pkg::PROW_W-1:0];
        res.pixel_column = s2_op_reg.col;
        res.pixel_height = mid;
        res.is_low_point = low;
        res.risk_total   = risk_new;
        res.frame_done   = s2_op_reg.done;

        risk_next = risk_reg;
        if (ctrl.restart)
        begin
            risk_next = '0;
        end
        else if (res_push)
        begin
            risk_next = s2_op_reg.done ? '0 : risk_new;
        end

        fwd_next          = fwd_reg;
        if (adv)
        begin
            fwd_next.mid_we   = mid_we;
            fwd_next.up_we    = up_we;
            fwd_next.addr     = s2_op_reg.col;
            fwd_next.mid_data = s2_op_reg.h;
            fwd_next.up_data  = mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            flush_x_reg   <= '0;
            flush_row_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            risk_reg      <= '0;
            fwd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_x_reg   <= flush_x_next;
            flush_row_reg <= flush_row_next;
            s1_valid_reg  <= s1_valid_next;
            if (adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            risk_reg      <= risk_next;
            fwd_reg       <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= s1_load;
            s2_op_reg <= s1_op_reg;
        end
        if (fire)
        begin
            left_reg <= mid;
        end
    end

endmodule

// ===== rtl/core/gld_checker.sv =====
// ----------------------------------------------------------------------------
// gld_checker
// Port-level checks on the result stream: reset state, held results, column
// order and a risk total that only grows within a frame.
// ----------------------------------------------------------------------------
module gld_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           empty,
    input logic                           pop,
    input logic [gld_pkg::PROW_W-1:0]     pixel_row,
    input logic [gld_pkg::COL_W-1:0]      pixel_column,
    input logic [gld_pkg::RISK_W-1:0]     risk_total,
    input logic                           frame_done
);

    logic                       take;
    logic                       have_prev_reg;
    logic                       prev_done_reg;
    logic [gld_pkg::COL_W-1:0]  prev_col_reg;
    logic [gld_pkg::RISK_W-1:0] prev_risk_reg;

    assign take = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_done_reg <= 1'b0;
            prev_col_reg  <= '0;
            prev_risk_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (take)
        begin
            have_prev_reg <= 1'b1;
            prev_done_reg <= frame_done;
            prev_col_reg  <= pixel_column;
            prev_risk_reg <= risk_total;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_row) && $stable(pixel_column)
                              && $stable(risk_total) && $stable(frame_done)))
        else $error("waiting result changed");

    a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
        (take && have_prev_reg && !prev_done_reg)
            |-> (pixel_column == prev_col_reg + 1'b1 || pixel_column == '0))
        else $error("decisions out of column order");

    a_risk_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && have_prev_reg && !prev_done_reg) |-> (risk_total >= prev_risk_reg))
        else $error("risk total fell within a frame");

endmodule

bind grid_local_minimum_detector gld_checker u_gld_checker (.*);
